// ===== hw/rtl/sscs_pkg.sv =====
// Package for the sparse set component store.
// Holds operation codes, fixed field widths and parameter defaults.
// No dependencies.
package sscs_pkg;

    // Fixed field widths of the stream items
    localparam int KEY_W   = 10;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 11;
    localparam int KIND_W  = 2;

    // Parameter defaults
    localparam int KEY_SPACE_DEF  = 1024;
    localparam int VALUE_BITS_DEF = 32;

    // Operation codes carried in the kind field
    localparam logic [KIND_W-1:0] KIND_ATTACH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DETACH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIND   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_WALK   = 2'd3;

endpackage

// ===== hw/rtl/sparse_set_component_store_top.sv =====
// Each accepted item passes through the states LOOK and DONE; a find or walk hit also
// passes through READ, and a detach hit through DET1 and DET2. No new item is accepted
// until the result is loaded into the output register, which waits while a held result is not taken; each
// item is sequenced through the three memories (key index, slot key, slot value) and one
// shared adder. Reset: rst_n clears control state, then a clearing pass marks every key
// absent, during which no item is accepted. Depends on sscs_pkg.
module sparse_set_component_store_top #(
    parameter int KEY_SPACE  = sscs_pkg::KEY_SPACE_DEF,
    parameter int VALUE_BITS = sscs_pkg::VALUE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input item
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // key[9:0], value_in[41:10], zero pad
    input  logic [2:0]  s_axis_tuser,   // kind[1:0], from_start[2]
    // result item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // value_out[31:0], next_key[41:32],
                                        // entry_count[52:42], zero pad
    output logic        m_axis_tuser    // hit
);

    localparam int AW = (KEY_SPACE > 1) ? $clog2(KEY_SPACE) : 1;
    localparam int CW = $clog2(KEY_SPACE + 1);
    localparam int KW = sscs_pkg::KEY_W;
    localparam int VB = VALUE_BITS;

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_DET1  = 3'd4;
    localparam logic [2:0] S_DET2  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // Memories: key index entry is {valid, slot}
    logic [AW:0]   k2s_mem [KEY_SPACE];
    logic [KW-1:0] s2k_mem [KEY_SPACE];
    logic [VB-1:0] sv_mem  [KEY_SPACE];

    logic [AW:0]   k2s_rdata_reg;
    logic [KW-1:0] s2k_rdata_reg;
    logic [VB-1:0] sv_rdata_reg;

    logic          k2s_we, s2k_we, sv_we;
    logic [AW-1:0] k2s_waddr, s2k_waddr, sv_waddr;
    logic [AW-1:0] k2s_raddr, s2k_raddr, sv_raddr;
    logic [AW:0]   k2s_wdata;
    logic [KW-1:0] s2k_wdata;
    logic [VB-1:0] sv_wdata;

    // Control state
    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg, out_valid_next;

    // Item and result holding registers
    logic [sscs_pkg::KIND_W-1:0] kind_reg;
    logic [KW-1:0]               key_reg;
    logic                        start_reg;
    logic [VB-1:0]               val_reg;
    logic [AW-1:0]               slot_reg;
    logic                        hit_reg, hit_next;
    logic [sscs_pkg::VALUE_W-1:0] vout_reg, vout_next;
    logic [KW-1:0]               nkey_reg, nkey_next;
    logic                        out_hit_reg;
    logic [sscs_pkg::VALUE_W-1:0] out_vout_reg;
    logic [KW-1:0]               out_nkey_reg;
    logic [sscs_pkg::COUNT_W-1:0] out_count_reg;

    // Shared adder: count or slot, plus one or minus one
    logic [CW-1:0] add_a, add_b, add_sum;
    logic          key_ok, present, use_cursor, in_accept, out_load;
    logic [AW-1:0] slot_w;
    logic [CW-1:0] walk_next;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign key_ok        = (32'(key_reg) < KEY_SPACE);
    assign present       = key_ok && k2s_rdata_reg[AW];
    assign slot_w        = k2s_rdata_reg[AW-1:0];
    assign use_cursor    = !start_reg && present;
    assign out_load      = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        add_a = count_reg;
        add_b = CW'(1);
        if (kind_reg == sscs_pkg::KIND_WALK)
        begin
            add_a = CW'(slot_w);
        end
        if (kind_reg == sscs_pkg::KIND_DETACH)
        begin
            add_b = {CW{1'b1}};
        end
    end
    assign add_sum   = add_a + add_b;
    assign walk_next = use_cursor ? add_sum : '0;

    // Memory read addresses
    assign k2s_raddr = AW'(s_axis_tdata[KW-1:0]);
    assign s2k_raddr = (kind_reg == sscs_pkg::KIND_DETACH) ? AW'(add_sum) : AW'(walk_next);
    assign sv_raddr  = (kind_reg == sscs_pkg::KIND_DETACH) ? AW'(add_sum) : slot_w;

    // Sequencer and memory write selection
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        hit_next       = hit_reg;
        vout_next      = vout_reg;
        nkey_next      = nkey_reg;
        k2s_we         = 1'b0;
        k2s_waddr      = AW'(key_reg);
        k2s_wdata      = '0;
        s2k_we         = 1'b0;
        s2k_waddr      = AW'(count_reg);
        s2k_wdata      = key_reg;
        sv_we          = 1'b0;
        sv_waddr       = AW'(count_reg);
        sv_wdata       = val_reg;
        case (state_reg)
            S_CLEAR:
            begin
                k2s_we    = 1'b1;
                k2s_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(KEY_SPACE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                hit_next   = 1'b0;
                vout_next  = '0;
                nkey_next  = '0;
                state_next = S_DONE;
                case (kind_reg)
                    sscs_pkg::KIND_ATTACH:
                    begin
                        if (present)
                        begin
                            hit_next = 1'b1;
                            sv_we    = 1'b1;
                            sv_waddr = slot_w;
                        end
                        else if (key_ok && (count_reg < CW'(KEY_SPACE)))
                        begin
                            sv_we      = 1'b1;
                            s2k_we     = 1'b1;
                            k2s_we     = 1'b1;
                            k2s_wdata  = {1'b1, AW'(count_reg)};
                            count_next = add_sum;
                        end
                    end
                    sscs_pkg::KIND_DETACH:
                    begin
                        if (present && (count_reg != '0))
                        begin
                            hit_next   = 1'b1;
                            state_next = S_DET1;
                        end
                    end
                    sscs_pkg::KIND_FIND:
                    begin
                        if (present)
                        begin
                            hit_next   = 1'b1;
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                        if (walk_next < count_reg)
                        begin
                            hit_next   = 1'b1;
                            state_next = S_READ;
                        end
                    end
                endcase
            end
            S_READ:
            begin
                if (kind_reg == sscs_pkg::KIND_FIND)
                begin
                    vout_next = sscs_pkg::VALUE_W'(sv_rdata_reg);
                end
                else
                begin
                    nkey_next = s2k_rdata_reg;
                end
                state_next = S_DONE;
            end
            S_DET1:
            begin
                // move last entry into the freed slot
                sv_we      = 1'b1;
                sv_waddr   = slot_reg;
                sv_wdata   = sv_rdata_reg;
                s2k_we     = 1'b1;
                s2k_waddr  = slot_reg;
                s2k_wdata  = s2k_rdata_reg;
                k2s_we     = 1'b1;
                k2s_waddr  = AW'(s2k_rdata_reg);
                k2s_wdata  = {1'b1, slot_reg};
                state_next = S_DET2;
            end
            S_DET2:
            begin
                // removed key goes absent last, also when it was the last entry
                k2s_we     = 1'b1;
                count_next = add_sum;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item, result and output payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg  <= s_axis_tuser[1:0];
            start_reg <= s_axis_tuser[2];
            key_reg   <= s_axis_tdata[KW-1:0];
            val_reg   <= VB'(s_axis_tdata[KW + sscs_pkg::VALUE_W - 1:KW]);
        end
        if (state_reg == S_LOOK)
        begin
            slot_reg <= slot_w;
        end
        hit_reg  <= hit_next;
        vout_reg <= vout_next;
        nkey_reg <= nkey_next;
        if (out_load)
        begin
            out_hit_reg   <= hit_reg;
            out_vout_reg  <= vout_reg;
            out_nkey_reg  <= nkey_reg;
            out_count_reg <= sscs_pkg::COUNT_W'(count_reg);
        end
    end

    // Key index memory
    always_ff @(posedge clk)
    begin
        if (k2s_we)
        begin
            k2s_mem[k2s_waddr] <= k2s_wdata;
        end
        k2s_rdata_reg <= k2s_mem[k2s_raddr];
    end

    // Slot key memory
    always_ff @(posedge clk)
    begin
        if (s2k_we)
        begin
            s2k_mem[s2k_waddr] <= s2k_wdata;
        end
        s2k_rdata_reg <= s2k_mem[s2k_raddr];
    end

    // Slot value memory
    always_ff @(posedge clk)
    begin
        if (sv_we)
        begin
            sv_mem[sv_waddr] <= sv_wdata;
        end
        sv_rdata_reg <= sv_mem[sv_raddr];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tdata  = {3'b000, out_count_reg, out_nkey_reg, out_vout_reg};

    // Stored count never passes the key space
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(KEY_SPACE))
        else $error("stored count above key space");

    // Count moves by at most one per cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + CW'(1)) ||
             (count_reg == $past(count_reg) - CW'(1))))
        else $error("stored count jumped");

    // An accepted item closes the input until its work is done
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_axis_tready)
        else $error("input accepted while busy");

    // Count changes only on attach or detach
    a_count_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((kind_reg == sscs_pkg::KIND_ATTACH) || (kind_reg == sscs_pkg::KIND_DETACH)))
        else $error("count changed on find or walk");

endmodule
